// ----- rtl/mf3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Register map codes, field widths and the records passed between modules.
// ----------------------------------------------------------------------------
package mf3_pkg;

  // Parameter defaults
  localparam int DEF_MAX_LINE_SAMPLES = 16384;
  localparam int DEF_MAX_CHANNELS     = 4;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int WIDTH_W   = 13;
  localparam int HEIGHT_W  = 13;
  localparam int CHANCFG_W = 3;
  localparam int CH_W      = 4;   // holds channel counts up to eight
  localparam int SIZE_W    = 17;  // holds samples per row up to 65536

  localparam logic [WIDTH_W-1:0]   RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [HEIGHT_W-1:0]  RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CHANCFG_W-1:0] RST_CHANNEL_COUNT = 3'd1;

  localparam int MAX_IMAGE_DIM = 4096;

  // Data path
  localparam int PIX_W = 8;
  localparam int COL_W = 3 * PIX_W;  // top, middle, bottom byte of one column
  localparam int ROW_W = 12;
  localparam int IDX_W = 14;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CNT_W = 4;

  // Saturated frame geometry, plus the write strobe of the register port
  typedef struct packed {
    logic                wr;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [CH_W-1:0]     chans;
    logic [SIZE_W-1:0]   size;
  } geom_t;

  // One queue entry: the results caused by one input word
  typedef struct packed {
    logic [PIX_W-1:0] med0;
    logic [PIX_W-1:0] med1;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic             two;
    logic             eof;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/mf3_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_cfg: configuration registers
// APB-style register file and saturation of the frame geometry.
// ----------------------------------------------------------------------------
module mf3_cfg #(
  parameter int MAX_LINE_SAMPLES = mf3_pkg::DEF_MAX_LINE_SAMPLES,
  parameter int MAX_CHANNELS     = mf3_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mf3_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mf3_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mf3_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output mf3_pkg::geom_t                    geom
);

  logic [mf3_pkg::WIDTH_W-1:0]   width_r;
  logic [mf3_pkg::HEIGHT_W-1:0]  height_r;
  logic [mf3_pkg::CHANCFG_W-1:0] chans_r;

  logic                          wr_en;
  logic [1:0]                    reg_sel;
  logic [mf3_pkg::CH_W-1:0]      chans_sat;
  logic [mf3_pkg::WIDTH_W-1:0]   wmax;
  logic [mf3_pkg::WIDTH_W-1:0]   width_lo;
  logic [mf3_pkg::WIDTH_W-1:0]   width_sat;
  logic [mf3_pkg::HEIGHT_W-1:0]  height_sat;
  logic [mf3_pkg::WIDTH_W-1:0]   wmax_tab [MAX_CHANNELS];

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mf3_pkg::RST_IMAGE_WIDTH;
      height_r <= mf3_pkg::RST_IMAGE_HEIGHT;
      chans_r  <= mf3_pkg::RST_CHANNEL_COUNT;
    end else if (wr_en) begin
      unique case (reg_sel)
        mf3_pkg::REG_IMAGE_WIDTH:   width_r  <= pwdata[mf3_pkg::WIDTH_W-1:0];
        mf3_pkg::REG_IMAGE_HEIGHT:  height_r <= pwdata[mf3_pkg::HEIGHT_W-1:0];
        mf3_pkg::REG_CHANNEL_COUNT: chans_r  <= pwdata[mf3_pkg::CHANCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mf3_pkg::REG_IMAGE_WIDTH:   prdata = mf3_pkg::PDATA_W'(width_r);
      mf3_pkg::REG_IMAGE_HEIGHT:  prdata = mf3_pkg::PDATA_W'(height_r);
      mf3_pkg::REG_CHANNEL_COUNT: prdata = mf3_pkg::PDATA_W'(chans_r);
      default:                    prdata = '0;
    endcase
  end

  // Widest row per channel count: line store / channels, within 2..4096
  for (genvar Gk = 1; Gk <= MAX_CHANNELS; Gk++) begin : g_wmax
    localparam int Quot    = MAX_LINE_SAMPLES / Gk;
    localparam int Capped  = (Quot > mf3_pkg::MAX_IMAGE_DIM) ? mf3_pkg::MAX_IMAGE_DIM : Quot;
    localparam int Floored = (Capped < 2) ? 2 : Capped;
    assign wmax_tab[Gk-1] = mf3_pkg::WIDTH_W'(Floored);
  end

  always_comb begin
    if (chans_r == '0) begin
      chans_sat = mf3_pkg::CH_W'(1);
    end else if (mf3_pkg::CH_W'(chans_r) > mf3_pkg::CH_W'(MAX_CHANNELS)) begin
      chans_sat = mf3_pkg::CH_W'(MAX_CHANNELS);
    end else begin
      chans_sat = mf3_pkg::CH_W'(chans_r);
    end

    wmax = wmax_tab[0];
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (chans_sat == mf3_pkg::CH_W'(k + 1)) wmax = wmax_tab[k];
    end

    width_lo  = (width_r < mf3_pkg::WIDTH_W'(2)) ? mf3_pkg::WIDTH_W'(2) : width_r;
    width_sat = (width_lo > wmax) ? wmax : width_lo;

    if (height_r == '0) begin
      height_sat = mf3_pkg::HEIGHT_W'(1);
    end else if (height_r > mf3_pkg::HEIGHT_W'(mf3_pkg::MAX_IMAGE_DIM)) begin
      height_sat = mf3_pkg::HEIGHT_W'(mf3_pkg::MAX_IMAGE_DIM);
    end else begin
      height_sat = height_r;
    end
  end

  assign geom.wr     = wr_en;
  assign geom.width  = width_sat;
  assign geom.height = height_sat;
  assign geom.chans  = chans_sat;
  assign geom.size   = mf3_pkg::SIZE_W'(width_sat) * mf3_pkg::SIZE_W'(chans_sat);

endmodule
`default_nettype wire

// ----- rtl/mf3_line_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_line_mem: line store
// Both buffered rows side by side in one word: older row high, newer low.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mf3_line_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [2*mf3_pkg::PIX_W-1:0]  rd_data,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [2*mf3_pkg::PIX_W-1:0]  wr_data
);

  logic [2*mf3_pkg::PIX_W-1:0] mem [DEPTH];
  logic [2*mf3_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/mf3_median.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_median: median of nine
// 19-exchange network in two halves with a register between them.
// ----------------------------------------------------------------------------
module mf3_median (
  input  wire logic                        clk,
  input  wire logic [mf3_pkg::COL_W-1:0]   col_l,
  input  wire logic [mf3_pkg::COL_W-1:0]   col_m,
  input  wire logic [mf3_pkg::COL_W-1:0]   col_r,
  output logic      [mf3_pkg::PIX_W-1:0]   med
);

  logic [mf3_pkg::PIX_W-1:0] va   [9];
  logic [mf3_pkg::PIX_W-1:0] va_r [9];
  logic [mf3_pkg::PIX_W-1:0] vb   [9];

  // Returns {larger, smaller}
  function automatic logic [2*mf3_pkg::PIX_W-1:0] ord2(input logic [mf3_pkg::PIX_W-1:0] a,
                                                        input logic [mf3_pkg::PIX_W-1:0] b);
    ord2 = (a > b) ? {a, b} : {b, a};
  endfunction

  // First half: sort each row, then the first merge level
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[3*k+0] = col_l[8*k +: 8];
      va[3*k+1] = col_m[8*k +: 8];
      va[3*k+2] = col_r[8*k +: 8];
    end
    {va[2], va[1]} = ord2(va[1], va[2]);
    {va[5], va[4]} = ord2(va[4], va[5]);
    {va[8], va[7]} = ord2(va[7], va[8]);
    {va[1], va[0]} = ord2(va[0], va[1]);
    {va[4], va[3]} = ord2(va[3], va[4]);
    {va[7], va[6]} = ord2(va[6], va[7]);
    {va[2], va[1]} = ord2(va[1], va[2]);
    {va[5], va[4]} = ord2(va[4], va[5]);
    {va[8], va[7]} = ord2(va[7], va[8]);
    {va[3], va[0]} = ord2(va[0], va[3]);
    {va[8], va[5]} = ord2(va[5], va[8]);
    {va[7], va[4]} = ord2(va[4], va[7]);
  end

  always_ff @(posedge clk) begin
    va_r <= va;
  end

  always_comb begin
    vb = va_r;
    {vb[6], vb[3]} = ord2(vb[3], vb[6]);
    {vb[4], vb[1]} = ord2(vb[1], vb[4]);
    {vb[5], vb[2]} = ord2(vb[2], vb[5]);
    {vb[7], vb[4]} = ord2(vb[4], vb[7]);
    {vb[2], vb[4]} = ord2(vb[4], vb[2]);
    {vb[4], vb[6]} = ord2(vb[6], vb[4]);
    {vb[2], vb[4]} = ord2(vb[4], vb[2]);
  end

  assign med = vb[4];

endmodule
`default_nettype wire

// ----- rtl/mf3_res_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_res_queue: result queue
// One entry per input word that gave results; a two-result entry is sent
// as two words on the output channel.
// ----------------------------------------------------------------------------
module mf3_res_queue (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  input  mf3_pkg::res_t                         push_data,
  output logic      [mf3_pkg::FIFO_CNT_W-1:0]   count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [mf3_pkg::PIX_W-1:0]        out_median,
  output logic      [mf3_pkg::ROW_W-1:0]        out_row,
  output logic      [mf3_pkg::IDX_W-1:0]        out_index,
  output logic                                  out_end_of_frame,
  output logic                                  out_last_of_step
);

  mf3_pkg::res_t                   mem_r [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [mf3_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [mf3_pkg::FIFO_CNT_W-1:0]  count_r;
  logic                            phase_r;

  mf3_pkg::res_t                   head;
  logic                            pop_word;
  logic                            pop_entry;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign pop_word  = out_valid && !out_stall;
  assign pop_entry = pop_word && (phase_r || !head.two);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      phase_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_entry) rd_ptr_r <= rd_ptr_r + 1'b1;
      // advance to the second result of the entry, or drop the entry
      if (pop_word) phase_r <= !pop_entry;
      count_r <= count_r + mf3_pkg::FIFO_CNT_W'(push) - mf3_pkg::FIFO_CNT_W'(pop_entry);
    end
  end

  always_comb begin
    out_row = head.row;
    if (phase_r) begin
      out_median       = head.med1;
      out_index        = head.idx1;
      out_end_of_frame = head.eof;
      out_last_of_step = 1'b1;
    end else begin
      out_median       = head.med0;
      out_index        = head.idx0;
      out_end_of_frame = head.eof && !head.two;
      out_last_of_step = !head.two;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/median_filter_3x3_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_core: streaming 3x3 median filter
// Interleaved 8-bit samples in raster order; each channel filtered on its own.
// ----------------------------------------------------------------------------
// Input channel (in_*): one sample word per accepted cycle. Once all rows of
// the frame are in, the next width*channels words drain the bottom row; their
// sample is ignored. Output channel (out_*): one median word per cycle.
// Registers (APB): image_width at 0x0, image_height at 0x4, channel_count at
// 0x8; write them only while no results are outstanding.
// Throughput: one input word per clock unless stalled, limited by the single
// read and single write port of the line store. Words of the last pixel of a
// row give two results, so over a row input and output rates match.
// Path: from the input word that causes it, a result passes through the line
// store read, the window update and the two halves of the sort network, then
// waits in an 8-entry queue; in_stall rises when the queue could overflow.
// After a register write, in_stall stays high while the channel phase of the
// sample counter is recomputed.
// Reset clears counters, window and queue, sets the registers to defaults;
// the line store is not cleared, since the edge rows are replicated and
// unwritten entries never reach an output. A stalled output holds its word;
// the pipeline still drains into the queue.
// ----------------------------------------------------------------------------
module median_filter_3x3_core #(
  parameter int MAX_LINE_SAMPLES = mf3_pkg::DEF_MAX_LINE_SAMPLES,
  parameter int MAX_CHANNELS     = mf3_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mf3_pkg::PIX_W-1:0]     in_sample,
  input  wire logic                          in_flush,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [mf3_pkg::PIX_W-1:0]     out_median,
  output logic      [mf3_pkg::ROW_W-1:0]     out_row,
  output logic      [mf3_pkg::IDX_W-1:0]     out_index,
  output logic                               out_end_of_frame,
  output logic                               out_last_of_step,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mf3_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mf3_pkg::PDATA_W-1:0]   pwdata,
  output logic      [mf3_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int LineStore = (MAX_LINE_SAMPLES > 2 * MAX_CHANNELS) ?
                             MAX_LINE_SAMPLES : 2 * MAX_CHANNELS;
  localparam int IW  = $clog2(LineStore);
  localparam int DCW = $clog2(IW);
  localparam int WCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW  = mf3_pkg::SIZE_W;
  localparam int HW  = mf3_pkg::HEIGHT_W;
  localparam int PW  = mf3_pkg::PIX_W;
  localparam int CW  = mf3_pkg::COL_W;

  mf3_pkg::geom_t geom;

  // Counters
  logic [IW-1:0]     i_r;
  logic [WCW-1:0]    c_r;
  logic [HW-1:0]     r_r;

  // Channel phase recompute after a register write
  logic              busy_r;
  logic [DCW-1:0]    dcnt_r;
  logic [WCW-1:0]    rem_r;
  logic [WCW:0]      rem_sh;
  logic [WCW:0]      rem_nxt;

  // Issue stage
  logic              accept;
  logic              i_over;
  logic [IW-1:0]     i_eff;
  logic [SW-1:0]     i_ext;
  logic [WCW-1:0]    c_eff;
  logic [HW-1:0]     r_eff;
  logic              draining;
  logic              emit_a;
  logic              emit_b;
  logic              left_cb;
  logic              eof;
  logic [SW-1:0]     i_inc;
  logic              wrap;
  logic [SW-1:0]     idx_a;

  // Window stage
  logic              v1_r;
  logic [IW-1:0]     addr1_r;
  logic [WCW-1:0]    c1_r;
  logic [PW-1:0]     sample1_r;
  logic              drain1_r;
  logic              topmid1_r;
  logic              emit_a1_r;
  logic              emit_b1_r;
  logic              left_cb1_r;
  logic              eof1_r;
  logic [mf3_pkg::ROW_W-1:0] row1_r;
  logic [mf3_pkg::IDX_W-1:0] idx_a1_r;
  logic [mf3_pkg::IDX_W-1:0] idx_b1_r;

  logic [2*PW-1:0]   rd_data;
  logic [PW-1:0]     mid;
  logic [PW-1:0]     top;
  logic [PW-1:0]     bot;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     ca;
  logic [CW-1:0]     cb;
  logic [CW-1:0]     win_a_r [MAX_CHANNELS];
  logic [CW-1:0]     win_b_r [MAX_CHANNELS];

  // Sort stages
  logic              v2_r;
  logic [CW-1:0]     left2_r;
  logic [CW-1:0]     cb2_r;
  logic [CW-1:0]     cur2_r;
  logic              two2_r;
  logic              eof2_r;
  logic [mf3_pkg::ROW_W-1:0] row2_r;
  logic [mf3_pkg::IDX_W-1:0] idx_a2_r;
  logic [mf3_pkg::IDX_W-1:0] idx_b2_r;

  logic              v3_r;
  logic              two3_r;
  logic              eof3_r;
  logic [mf3_pkg::ROW_W-1:0] row3_r;
  logic [mf3_pkg::IDX_W-1:0] idx_a3_r;
  logic [mf3_pkg::IDX_W-1:0] idx_b3_r;

  logic [PW-1:0]     med_a;
  logic [PW-1:0]     med_b;
  mf3_pkg::res_t     push_data;
  logic [mf3_pkg::FIFO_CNT_W-1:0] q_count;
  logic [mf3_pkg::FIFO_CNT_W-1:0] committed;

  mf3_cfg #(
    .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // Reserve a queue entry for every word in flight before taking another.
  // The phase of the stream follows the row count, so in_flush only marks
  // drain words for the sender's benefit.
  assign committed = q_count + mf3_pkg::FIFO_CNT_W'(v1_r) + mf3_pkg::FIFO_CNT_W'(v2_r)
                     + mf3_pkg::FIFO_CNT_W'(v3_r);
  assign in_stall  = busy_r || geom.wr ||
                     (committed >= mf3_pkg::FIFO_CNT_W'(mf3_pkg::FIFO_DEPTH));
  assign accept    = in_valid && !in_stall;

  // Issue stage: clamp counters to the geometry, decide which results follow
  always_comb begin
    i_over   = ({{(SW-IW){1'b0}}, i_r} >= geom.size);
    i_eff    = i_over ? '0 : i_r;
    c_eff    = i_over ? '0 : c_r;
    i_ext    = SW'(i_eff);
    r_eff    = (r_r > geom.height) ? geom.height : r_r;
    draining = (r_eff >= geom.height);

    emit_a   = (r_eff != '0) && (i_ext >= SW'(geom.chans));
    left_cb  = (i_ext < (SW'(geom.chans) << 1));
    emit_b   = emit_a && (i_ext >= (geom.size - SW'(geom.chans)));
    eof      = draining && (i_ext == (geom.size - SW'(1)));
    idx_a    = i_ext - SW'(geom.chans);

    i_inc    = i_ext + SW'(1);
    wrap     = (i_inc >= geom.size);
  end

  // Remainder step of the channel phase recompute, most significant bit first
  always_comb begin
    rem_sh  = {rem_r, i_r[dcnt_r]};
    rem_nxt = rem_sh;
    if (mf3_pkg::CH_W'(rem_sh) >= geom.chans) begin
      rem_nxt = (WCW+1)'(mf3_pkg::CH_W'(rem_sh) - geom.chans);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      c_r    <= '0;
      r_r    <= '0;
      busy_r <= 1'b0;
      dcnt_r <= '0;
      rem_r  <= '0;
    end else if (geom.wr) begin
      busy_r <= 1'b1;
      dcnt_r <= DCW'(IW - 1);
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= WCW'(rem_nxt);
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == '0) begin
        c_r    <= WCW'(rem_nxt);
        busy_r <= 1'b0;
      end
    end else if (accept) begin
      if (wrap) begin
        i_r <= '0;
        c_r <= '0;
        r_r <= draining ? '0 : r_eff + 1'b1;
      end else begin
        i_r <= i_inc[IW-1:0];
        c_r <= ((mf3_pkg::CH_W'(c_eff) + 1'b1) == geom.chans) ? '0 : c_eff + 1'b1;
        r_r <= r_eff;
      end
    end
  end

  mf3_line_mem #(
    .DEPTH (LineStore),
    .AW    (IW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (i_eff),
    .rd_data (rd_data),
    .wr_en   (v1_r && !drain1_r),
    .wr_addr (addr1_r),
    .wr_data ({mid, sample1_r})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1_r    <= i_eff;
      c1_r       <= c_eff;
      sample1_r  <= in_sample;
      drain1_r   <= draining;
      topmid1_r  <= (r_eff <= HW'(1));
      emit_a1_r  <= emit_a;
      emit_b1_r  <= emit_b;
      left_cb1_r <= left_cb;
      eof1_r     <= eof;
      row1_r     <= mf3_pkg::ROW_W'(r_eff - 1'b1);
      idx_a1_r   <= idx_a[mf3_pkg::IDX_W-1:0];
      idx_b1_r   <= i_ext[mf3_pkg::IDX_W-1:0];
    end
  end

  // Window stage: build the new column and shift the per-channel window
  always_comb begin
    mid = rd_data[PW-1:0];
    top = topmid1_r ? mid : rd_data[2*PW-1:PW];
    bot = drain1_r ? mid : sample1_r;
    cur = {bot, mid, top};
    ca  = win_a_r[c1_r];
    cb  = win_b_r[c1_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        win_a_r[k] <= '0;
        win_b_r[k] <= '0;
      end
    end else if (v1_r) begin
      win_a_r[c1_r] <= cb;
      win_b_r[c1_r] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v1_r && emit_a1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    left2_r  <= left_cb1_r ? cb : ca;
    cb2_r    <= cb;
    cur2_r   <= cur;
    two2_r   <= emit_b1_r;
    eof2_r   <= eof1_r;
    row2_r   <= row1_r;
    idx_a2_r <= idx_a1_r;
    idx_b2_r <= idx_b1_r;

    two3_r   <= two2_r;
    eof3_r   <= eof2_r;
    row3_r   <= row2_r;
    idx_a3_r <= idx_a2_r;
    idx_b3_r <= idx_b2_r;
  end

  mf3_median u_med_a (
    .clk   (clk),
    .col_l (left2_r),
    .col_m (cb2_r),
    .col_r (cur2_r),
    .med   (med_a)
  );

  // Right edge: replicate the last column
  mf3_median u_med_b (
    .clk   (clk),
    .col_l (cb2_r),
    .col_m (cur2_r),
    .col_r (cur2_r),
    .med   (med_b)
  );

  always_comb begin
    push_data.med0 = med_a;
    push_data.med1 = med_b;
    push_data.row  = row3_r;
    push_data.idx0 = idx_a3_r;
    push_data.idx1 = idx_b3_r;
    push_data.two  = two3_r;
    push_data.eof  = eof3_r;
  end

  mf3_res_queue u_res_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (v3_r),
    .push_data        (push_data),
    .count            (q_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median       (out_median),
    .out_row          (out_row),
    .out_index        (out_index),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_step (out_last_of_step)
  );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: streaming check of the 3x3 median filter core
// Drives sample words and drain words frame by frame over several register
// settings, predicts every median with its position and flags, and compares
// each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mf3_pkg::*;

  localparam int LINE_SAMPLES  = DEF_MAX_LINE_SAMPLES;
  localparam int MAX_CH        = DEF_MAX_CHANNELS;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int RANDOM_WORDS  = 500;

  // compare-exchange pairs of the median-of-nine network
  localparam int NET_LO [19] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int NET_HI [19] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] index;
    logic             eof;
    logic             last;
  } median_result_t;

  typedef enum logic [1:0] {DIR_READ, DIR_WRITE, DIR_WORD} dir_op_e;

  typedef struct packed {
    dir_op_e          op;
    logic [1:0]       regsel;
    logic [12:0]      value;
    logic [PIX_W-1:0] smp;
    logic             flush;
    logic             typed;
    logic [PIX_W-1:0] tmed;
  } dir_row_t;

  localparam int DIR_ROWS = 36;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // registers out of reset
    '{DIR_READ,  REG_IMAGE_WIDTH,   13'd640,  8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_READ,  REG_IMAGE_HEIGHT,  13'd480,  8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_READ,  REG_CHANNEL_COUNT, 13'd1,    8'h00, 1'b0, 1'b0, 8'h00},
    // width and height below range: smallest frame, flat white
    '{DIR_WRITE, REG_IMAGE_WIDTH,   13'd1,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_IMAGE_HEIGHT,  13'd0,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_CHANNEL_COUNT, 13'd1,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h00, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h03, 1'b1, 1'b1, 8'hFF},
    // zero channels, two rows of extremes, flush bit ignored on data
    '{DIR_WRITE, REG_IMAGE_WIDTH,   13'd3,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_IMAGE_HEIGHT,  13'd2,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_CHANNEL_COUNT, 13'd0,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h00, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h80, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h00, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h01, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h5A, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hA5, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFF, 1'b1, 1'b0, 8'h00},
    // all register bits set, then a partial first row
    '{DIR_WRITE, REG_IMAGE_WIDTH,   13'd8191, 8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_IMAGE_HEIGHT,  13'd8191, 8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_CHANNEL_COUNT, 13'd7,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h01, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h80, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hFE, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h7F, 1'b1, 1'b0, 8'h00},
    // shrink the row below the sample counter: counter restarts, flat black
    '{DIR_WRITE, REG_IMAGE_WIDTH,   13'd2,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_IMAGE_HEIGHT,  13'd1,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WRITE, REG_CHANNEL_COUNT, 13'd1,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h00, 1'b0, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'h55, 1'b1, 1'b0, 8'h00},
    '{DIR_WORD,  '0,                13'd0,    8'hAA, 1'b0, 1'b1, 8'h00}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_sample = '0;
  logic               in_flush = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   out_median;
  logic [ROW_W-1:0]   out_row;
  logic [IDX_W-1:0]   out_index;
  logic               out_end_of_frame;
  logic               out_last_of_step;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor copy of registers and state
  int unsigned      width_reg = 640;
  int unsigned      height_reg = 480;
  int unsigned      chans_reg = 1;
  bit [PIX_W-1:0]   row_two_up [LINE_SAMPLES];
  bit [PIX_W-1:0]   row_one_up [LINE_SAMPLES];
  int unsigned      row_pos = 0;
  int unsigned      sample_pos = 0;
  bit [COL_W-1:0]   win_cols [2*MAX_CH];

  median_result_t median_queue [$];
  int             error_count = 0;
  int             send_pct = 30;
  int             recv_pct = 69;

  median_filter_3x3_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_flush         (in_flush),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median       (out_median),
    .out_row          (out_row),
    .out_index        (out_index),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_step (out_last_of_step),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  function automatic logic [PIX_W-1:0] median_of_nine(input bit [COL_W-1:0] lft,
                                                       input bit [COL_W-1:0] ctr,
                                                       input bit [COL_W-1:0] rgt);
    bit [PIX_W-1:0] v [9];
    bit [PIX_W-1:0] t;
    for (int k = 0; k < 3; k++) begin
      v[3*k]   = lft[8*k +: 8];
      v[3*k+1] = ctr[8*k +: 8];
      v[3*k+2] = rgt[8*k +: 8];
    end
    for (int k = 0; k < 19; k++) begin
      if (v[NET_LO[k]] > v[NET_HI[k]]) begin
        t = v[NET_LO[k]];
        v[NET_LO[k]] = v[NET_HI[k]];
        v[NET_HI[k]] = t;
      end
    end
    return v[4];
  endfunction

  // Advance the predictor by one accepted word and queue the medians it causes.
  task automatic filter_word(input logic [PIX_W-1:0] smp, input logic typed,
                             input logic [PIX_W-1:0] tmed);
    int unsigned    ch, wmax, w, h, size, i, r, p, c;
    bit             draining;
    bit [PIX_W-1:0] mid, top, bot;
    bit [COL_W-1:0] cur, ca, cb;
    median_result_t res [2];
    int             n;
    ch = chans_reg;
    if (ch < 1) ch = 1;
    if (ch > MAX_CH) ch = MAX_CH;
    wmax = LINE_SAMPLES / ch;
    if (wmax > MAX_IMAGE_DIM) wmax = MAX_IMAGE_DIM;
    if (wmax < 2) wmax = 2;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > wmax) w = wmax;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_IMAGE_DIM) h = MAX_IMAGE_DIM;
    size = w * ch;

    i = (sample_pos >= size) ? 0 : sample_pos;
    r = (row_pos > h) ? h : row_pos;
    p = i / ch;
    c = i % ch;
    draining = (r >= h);

    mid = row_one_up[i];
    top = (r <= 1) ? mid : row_two_up[i];
    bot = draining ? mid : smp;
    cur = {bot, mid, top};
    if (!draining) begin
      row_two_up[i] = row_one_up[i];
      row_one_up[i] = smp;
    end

    ca = win_cols[c];
    cb = win_cols[MAX_CH + c];
    n = 0;
    if (r >= 1 && p >= 1) begin
      res[0] = '0;
      res[0].median = median_of_nine((p == 1) ? cb : ca, cb, cur);
      res[0].row    = ROW_W'(r - 1);
      res[0].index  = IDX_W'(i - ch);
      n = 1;
      // last pixel of the row also closes itself out
      if (p == w - 1) begin
        res[1] = '0;
        res[1].median = median_of_nine(cb, cur, cur);
        res[1].row    = ROW_W'(r - 1);
        res[1].index  = IDX_W'(i);
        n = 2;
      end
    end
    win_cols[c] = cb;
    win_cols[MAX_CH + c] = cur;

    if (n > 0) begin
      res[n-1].last = 1'b1;
      if (draining && i == size - 1) res[n-1].eof = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      if (typed) res[k].median = tmed;
      median_queue.push_back(res[k]);
    end

    i++;
    if (i >= size) begin
      i = 0;
      r = draining ? 0 : r + 1;
    end
    sample_pos = i;
    row_pos = r;
  endtask

  // Present one word, hold it until taken, then predict.
  task automatic send_word(input logic [PIX_W-1:0] smp, input logic flush,
                           input logic typed, input logic [PIX_W-1:0] tmed);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_flush  <= flush;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_word(smp, typed, tmed);
  endtask

  // Drop valid and wait until every result is out and the pipeline is empty.
  task automatic go_quiet();
    in_valid <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] regsel, input logic [12:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({regsel, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (regsel)
      REG_IMAGE_WIDTH:   width_reg  = value;
      REG_IMAGE_HEIGHT:  height_reg = value;
      REG_CHANNEL_COUNT: chans_reg  = value & 13'h7;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_check(input logic [1:0] regsel, input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({regsel, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One random frame; sometimes cut short and the height lowered under the
  // row counter so that the block drains early.
  task automatic run_frame(inout int words);
    int unsigned w, h, ch, k, row_len;
    bit          cut;
    w  = ($urandom_range(9) == 0) ? $urandom_range(16, 64) : $urandom_range(2, 6);
    h  = $urandom_range(1, 5);
    ch = $urandom_range(1, MAX_CH);
    cut = (h >= 2) && ($urandom_range(4) == 0);
    k = cut ? $urandom_range(2, h) : h;
    row_len = w * ch;

    go_quiet();
    write_reg(REG_IMAGE_WIDTH,
              13'((w == 2 && $urandom_range(1) == 1) ? $urandom_range(1) : w));
    write_reg(REG_IMAGE_HEIGHT,
              13'((h == 1 && $urandom_range(1) == 1) ? 0 : h));
    if (ch == MAX_CH && $urandom_range(1) == 1)
      write_reg(REG_CHANNEL_COUNT, 13'($urandom_range(MAX_CH + 1, 7)));
    else if (ch == 1 && $urandom_range(1) == 1)
      write_reg(REG_CHANNEL_COUNT, 13'd0);
    else
      write_reg(REG_CHANNEL_COUNT, 13'(ch));

    for (int j = 0; j < k * row_len; j++)
      send_word(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, 8'h00);
    if (cut) begin
      go_quiet();
      write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(1, k - 1)));
    end
    for (int j = 0; j < row_len; j++)
      send_word(8'($urandom_range(255)), $urandom_range(7) != 0, 1'b0, 8'h00);
    words += (k + 1) * row_len;
  endtask

  // receiver: random stall, check every result taken
  always @(posedge clk) begin : watch_results
    median_result_t want;
    out_stall <= ($urandom_range(99) < recv_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (median_queue.size() == 0) begin
        $error("out_median: no result expected, got %0d (row %0d index %0d)",
               out_median, out_row, out_index);
        error_count++;
      end else begin
        want = median_queue.pop_front();
        if (out_median !== want.median) begin
          $error("out_median: expected %0d, got %0d", want.median, out_median);
          error_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          error_count++;
        end
        if (out_index !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_index);
          error_count++;
        end
        if (out_end_of_frame !== want.eof) begin
          $error("out_end_of_frame: expected %0d, got %0d", want.eof, out_end_of_frame);
          error_count++;
        end
        if (out_last_of_step !== want.last) begin
          $error("out_last_of_step: expected %0d, got %0d", want.last, out_last_of_step);
          error_count++;
        end
      end
    end
  end

  initial begin : run
    dir_row_t row;
    int       words;
    words = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[n]) begin
      row = DIRECTED[n];
      case (row.op)
        DIR_READ: begin
          go_quiet();
          read_check(row.regsel, PDATA_W'(row.value));
        end
        DIR_WRITE: begin
          go_quiet();
          write_reg(row.regsel, row.value);
        end
        default: send_word(row.smp, row.flush, row.typed, row.tmed);
      endcase
    end

    while (words < RANDOM_WORDS) begin
      // swap idling between the two sides, then run flat out
      if (words < RANDOM_WORDS / 3) begin
        send_pct = 30;
        recv_pct = 69;
      end else if (words < 2 * RANDOM_WORDS / 3) begin
        send_pct = 69;
        recv_pct = 30;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      run_frame(words);
    end

    in_valid <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #800000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- median_filter_3x3_core.f -----
rtl/mf3_pkg.sv
rtl/mf3_cfg.sv
rtl/mf3_line_mem.sv
rtl/mf3_median.sv
rtl/mf3_res_queue.sv
rtl/median_filter_3x3_core.sv
dv/testbench.sv
